### sv/hws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hws_pkg
// Shared constants and types for the harmonic waveform synthesizer.
// ----------------------------------------------------------------------------
package hws_pkg;

  localparam int unsigned HARM_NUM     = 5;
  localparam int unsigned POINTS_DEF   = 320;
  localparam int unsigned SINE_DEPTH_DEF = 256;
  localparam int unsigned FULL_SCALE   = 32767;
  localparam int unsigned SCREEN_H     = 240;

  localparam int unsigned COL_W   = 9;
  localparam int unsigned AMP_W   = 16;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned HGT_W   = 8;
  localparam int unsigned ASUM_W  = 19;   // 5 * 65535
  localparam int unsigned DEN_W   = 36;   // 2 * asum * 32767
  localparam int unsigned NUM_W   = 44;   // 240 * (S + D) + D
  localparam int unsigned QUO_W   = 8;

  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;

  // Divider input word
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             invalid;
  } div_word_t;

endpackage

### sv/hws_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hws_div
// Pipelined restoring divider, one quotient bit per stage, 8-bit quotient.
// ----------------------------------------------------------------------------
module hws_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  hws_pkg::div_word_t      in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [hws_pkg::HGT_W-1:0] out_height,
  output logic                    out_invalid
);
  import hws_pkg::*;

  localparam int unsigned NST = QUO_W;

  logic             v_r   [NST];
  logic [NUM_W-1:0] rem_r [NST];
  logic [DEN_W-1:0] den_r [NST];
  logic [QUO_W-1:0] quo_r [NST];
  logic             inv_r [NST];
  logic             en    [NST+1];

  assign en[NST] = out_ready;
  assign in_ready = en[0];

  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             inv_in;
    logic             v_in;
    logic [NUM_W-1:0] dsh;
    logic             ge;

    assign en[j] = !v_r[j] || en[j+1];

    if (j == 0) begin : g_first
      assign rem_in = in_word.num;
      assign den_in = in_word.den;
      assign quo_in = '0;
      assign inv_in = in_word.invalid;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
      assign inv_in = inv_r[j-1];
      assign v_in   = v_r[j-1];
    end

    assign dsh = NUM_W'(den_in) << (NST - 1 - j);
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= v_in;
      end
      if (en[j]) begin
        rem_r[j] <= ge ? rem_in - dsh : rem_in;
        den_r[j] <= den_in;
        quo_r[j] <= quo_in | (QUO_W'(ge) << (NST - 1 - j));
        inv_r[j] <= inv_in;
      end
    end
  end

  assign out_valid   = v_r[NST-1];
  assign out_invalid = inv_r[NST-1];
  assign out_height  = inv_r[NST-1] ? '0 : quo_r[NST-1];

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |-> quo_r[NST-1] <= HGT_W'(SCREEN_H))
    else $error("height above screen");
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !inv_r[0] |-> den_r[0] != '0)
    else $error("zero divisor on valid word");
`endif

endmodule

### sv/harmonic_waveform_synth_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_waveform_synth_top
// Five-harmonic additive synthesis, one display column in, one height out.
// ----------------------------------------------------------------------------
// Pipeline: 17 register stages, 9 front stages plus 8 divider stages, one
//   quotient bit each.
// Throughput: one column per cycle while out_ready does not stall the pipe.
// Reset: synchronous active-low rst_n clears all stage valid bits and the
//   five harmonic registers.
module harmonic_waveform_synth_top #(
  parameter int unsigned POINTS           = hws_pkg::POINTS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = hws_pkg::SINE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // column channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hws_pkg::COL_W-1:0]    in_column,
  // height channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hws_pkg::HGT_W-1:0]    out_height,
  output logic                         out_invalid,
  // APB register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hws_pkg::APB_AW-1:0]   paddr,
  input  logic [hws_pkg::APB_DW-1:0]   pwdata,
  output logic [hws_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import hws_pkg::*;

  // Angle base = floor(m * 65536 / POINTS), m = (k+1)*column.
  // Estimated with a reciprocal (low by at most one), then fixed up.
  localparam int unsigned M_W     = 12;
  localparam int unsigned RSH     = 28;
  localparam longint unsigned RECIP = (64'd1 << RSH) / POINTS;
  localparam int unsigned RECIP_W = 25;
  localparam int unsigned PRD_W   = M_W + RECIP_W;
  localparam int unsigned Q_W     = 24;
  localparam int unsigned REM_W   = 30;
  localparam int unsigned PTS_W   = 13;
  localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DEP_W   = IDX_W + 1;
  localparam int unsigned SIN_W   = 16;
  localparam int unsigned PROD_W  = AMP_W + SIN_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 3;
  localparam int unsigned DHALF_W = DEN_W - 1;
  localparam int unsigned NST     = 9;

  typedef logic signed [SIN_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

  // Sine table in Q1.15, Taylor series to x^11 in Q30.
  function automatic sine_tab_t build_sine();
    sine_tab_t  tab;
    logic [63:0] p, r, x, x2, t, s, v;
    logic [1:0]  quad;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      p    = (64'(i) << 32) / SINE_TABLE_DEPTH;
      quad = p[31:30];
      r    = {34'd0, p[29:0]};
      if (quad[0]) r = (64'd1 << 30) - r;
      x  = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (v > 64'(FULL_SCALE)) v = 64'(FULL_SCALE);
      tab[i] = quad[1] ? -SIN_W'(v) : SIN_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // --------------------------------------------------------------------------
  // Harmonic registers
  // --------------------------------------------------------------------------
  logic [APB_DW-1:0] harm_r [HARM_NUM];
  logic [2:0]        reg_idx;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HARM_NUM; k++) harm_r[k] <= '0;
    end else if (psel && penable && pwrite && (32'(reg_idx) < HARM_NUM)) begin
      harm_r[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (32'(reg_idx) < HARM_NUM) prdata = harm_r[reg_idx];
  end

  // --------------------------------------------------------------------------
  // Front pipeline: stage valid bits and enable chain
  // --------------------------------------------------------------------------
  logic v_r [NST];
  logic en  [NST+1];
  logic div_ready;

  assign en[NST]  = div_ready;
  assign in_ready = en[0];

  for (genvar i = 0; i < NST; i++) begin : g_v
    logic v_in;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
    end else begin : g_next
      assign v_in = v_r[i-1];
    end

    assign en[i] = !v_r[i] || en[i+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en[i]) begin
        v_r[i] <= v_in;
      end
    end
  end

  // stage 0: column
  logic [COL_W-1:0] col_r;
  always_ff @(posedge clk) begin
    if (en[0]) col_r <= in_column;
  end

  // per-harmonic lanes, stages 1..6
  logic [M_W-1:0]         m_r    [HARM_NUM];
  logic [M_W-1:0]         m2_r   [HARM_NUM];
  logic [Q_W-1:0]         qe_r   [HARM_NUM];
  logic [PHASE_W-1:0]     base_r [HARM_NUM];
  logic [IDX_W-1:0]       idx_r  [HARM_NUM];
  logic signed [SIN_W-1:0] sin_r [HARM_NUM];
  logic signed [PROD_W-1:0] prod_r [HARM_NUM];

  for (genvar k = 0; k < HARM_NUM; k++) begin : g_lane
    logic [PRD_W-1:0]      qprod;
    logic [REM_W-1:0]      rem;
    logic [PHASE_W-1:0]    theta;
    logic [PHASE_W+DEP_W-1:0] scaled;

    assign qprod  = PRD_W'(m_r[k]) * PRD_W'(RECIP);
    assign rem    = (REM_W'(m2_r[k]) << 16) - REM_W'(qe_r[k]) * REM_W'(POINTS);
    assign theta  = base_r[k] + harm_r[k][PHASE_W-1:0];
    assign scaled = (PHASE_W+DEP_W)'(theta) * (PHASE_W+DEP_W)'(SINE_TABLE_DEPTH);

    always_ff @(posedge clk) begin
      if (en[1]) m_r[k]  <= M_W'(col_r) * M_W'(k + 1);
      if (en[2]) begin
        qe_r[k] <= qprod[RSH-16 +: Q_W];
        m2_r[k] <= m_r[k];
      end
      if (en[3]) base_r[k] <= qe_r[k][PHASE_W-1:0] +
                              PHASE_W'(rem >= REM_W'(POINTS));
      if (en[4]) idx_r[k] <= scaled[PHASE_W +: IDX_W];
      if (en[5]) sin_r[k] <= SINE_TAB[idx_r[k]];
      if (en[6]) prod_r[k] <= $signed({1'b0, harm_r[k][APB_DW-1 -: AMP_W]}) *
                              PROD_W'(sin_r[k]);
    end
  end

  // stage 7: sums
  logic signed [SUM_W-1:0] s_r;
  logic [ASUM_W-1:0]       asum_r;
  logic signed [SUM_W-1:0] s_nxt;
  logic [ASUM_W-1:0]       asum_nxt;

  always_comb begin
    s_nxt    = '0;
    asum_nxt = '0;
    for (int k = 0; k < HARM_NUM; k++) begin
      s_nxt    = s_nxt + SUM_W'(prod_r[k]);
      asum_nxt = asum_nxt + ASUM_W'(harm_r[k][APB_DW-1 -: AMP_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s_r    <= s_nxt;
      asum_r <= asum_nxt;
    end
  end

  // stage 8: numerator 240*(S+D)+D and divisor 2D
  logic [DHALF_W-1:0] d_full;
  logic [SUM_W-1:0]   x_sum;
  logic [NUM_W-1:0]   num_nxt;
  div_word_t          div_r;

  assign d_full  = (DHALF_W'(asum_r) << 15) - DHALF_W'(asum_r);
  assign x_sum   = s_r + SUM_W'(d_full);
  assign num_nxt = (NUM_W'(x_sum) << 8) - (NUM_W'(x_sum) << 4) + NUM_W'(d_full);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      div_r.num     <= num_nxt;
      div_r.den     <= {d_full, 1'b0};
      div_r.invalid <= (asum_r == '0);
    end
  end

  hws_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v_r[8]),
    .in_ready    (div_ready),
    .in_word     (div_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_height  (out_height),
    .out_invalid (out_invalid)
  );

`ifndef NO_ASSERTIONS
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ready)
    else $error("empty front stage not ready");
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[8] && !div_r.invalid |-> div_r.den != '0)
    else $error("divisor zero without invalid flag");
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_height == '0)
    else $error("invalid result with nonzero height");
`endif

endmodule

### test/hws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hws_checker
// Watches the column, height and register ports of the synthesizer. It keeps
// its own copy of the harmonic registers, predicts each height and compares
// the results in order.
// ----------------------------------------------------------------------------
module hws_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [hws_pkg::COL_W-1:0]   in_column,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [hws_pkg::HGT_W-1:0]   out_height,
  input  logic                        out_invalid,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [hws_pkg::APB_AW-1:0]  paddr,
  input  logic [hws_pkg::APB_DW-1:0]  pwdata,
  output int                          fail_count,
  output int                          heights_due,
  output int                          heights_seen
);
  import hws_pkg::*;

  typedef struct {
    logic [HGT_W-1:0] height;
    logic             invalid;
  } height_word_t;

  localparam longint unsigned Q30 = 64'd1 << 30;

  height_word_t       heights_q[$];
  logic [APB_DW-1:0]  harm_regs [HARM_NUM];
  int                 sine_q15  [SINE_DEPTH_DEF];

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic int sine_value(int unsigned i);
    longint unsigned p, r, x, x2, t, s, v;
    int unsigned quad;
    p    = (longint'(i) << 32) / SINE_DEPTH_DEF;
    quad = (p >> 30) & 3;
    r    = p & (Q30 - 1);
    if (quad[0]) r = Q30 - r;
    x  = q30_mul(r, 64'd1686629713);
    x2 = q30_mul(x, x);
    t  = Q30 - x2 / 110;
    t  = Q30 - q30_mul(x2, t) / 72;
    t  = Q30 - q30_mul(x2, t) / 42;
    t  = Q30 - q30_mul(x2, t) / 20;
    t  = Q30 - q30_mul(x2, t) / 6;
    s  = q30_mul(x, t);
    v  = (s * FULL_SCALE + (Q30 >> 1)) >> 30;
    if (v > FULL_SCALE) v = FULL_SCALE;
    return (quad >= 2) ? -int'(v) : int'(v);
  endfunction

  function automatic height_word_t column_height(logic [COL_W-1:0] col);
    height_word_t    res;
    longint          wave_sum;
    longint unsigned amp, phase, base, theta, idx, amp_sum, den, num;
    wave_sum = 0;
    amp_sum  = 0;
    for (int k = 0; k < HARM_NUM; k++) begin
      amp   = harm_regs[k][31:16];
      phase = harm_regs[k][15:0];
      base  = (longint'(k + 1) * col * 65536) / POINTS_DEF;
      theta = (base + phase) & 16'hFFFF;
      idx   = (theta * SINE_DEPTH_DEF) >> 16;
      if (idx >= SINE_DEPTH_DEF) idx = SINE_DEPTH_DEF - 1;
      wave_sum += longint'(amp) * sine_q15[idx];
      amp_sum  += amp;
    end
    if (amp_sum == 0) begin
      res.height  = '0;
      res.invalid = 1'b1;
    end else begin
      den = amp_sum * FULL_SCALE;
      num = longint'(wave_sum + longint'(den));
      num = (SCREEN_H * num + den) / (2 * den);
      if (num > SCREEN_H) num = SCREEN_H;
      res.height  = num[HGT_W-1:0];
      res.invalid = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    for (int i = 0; i < SINE_DEPTH_DEF; i++) sine_q15[i] = sine_value(i);
    fail_count   = 0;
    heights_seen = 0;
    heights_due  = 0;
  end

  always @(posedge clk) begin
    height_word_t want;
    if (!rst_n) begin
      foreach (harm_regs[k]) harm_regs[k] <= '0;
    end else begin
      // register writes; addresses past the last harmonic are dropped
      if (psel && penable && pwrite && pready && (paddr >> 2) < HARM_NUM)
        harm_regs[paddr >> 2] <= pwdata;
      if (in_valid && in_ready)
        heights_q.push_back(column_height(in_column));
      if (out_valid && out_ready) begin
        heights_seen++;
        if (heights_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word height=%0d invalid=%0b",
                                    out_height, out_invalid));
        end else begin
          want = heights_q.pop_front();
          if (out_height !== want.height)
            report_mismatch($sformatf("height %0d, expected %0d", out_height, want.height));
          if (out_invalid !== want.invalid)
            report_mismatch($sformatf("invalid %0b, expected %0b",
                                      out_invalid, want.invalid));
        end
      end
    end
    heights_due <= heights_q.size();
  end

endmodule

### test/tb_harmonic_waveform_synth_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_harmonic_waveform_synth_top
// Drives column words into the synthesizer under many harmonic settings,
// with random gaps on both channels, and lets hws_checker judge each height.
// ----------------------------------------------------------------------------
module tb_harmonic_waveform_synth_top;
  import hws_pkg::*;

  localparam int LATENCY = 17;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [COL_W-1:0]   in_column;
  logic               out_valid;
  logic               out_ready;
  logic [HGT_W-1:0]   out_height;
  logic               out_invalid;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int fail_count;
  int heights_due;
  int heights_seen;
  int columns_sent;
  int settings_used;
  bit no_idle;      // back-to-back stretch on both sides
  bit hold_req;     // ask the receiver for one long hold-off
  bit hold_done;    // the long hold-off has been served

  harmonic_waveform_synth_top uut (.*);

  hws_checker chk (.*);

  // 10 ns clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Timeout waiting for heights");
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall after each word, plus one long hold-off on request.
  int stall_left;
  always @(posedge clk) begin
    int stall_draw;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_done  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready  <= 1'b0;
      stall_left <= 150;  // long enough to back the pipe up into in_ready
      hold_done  <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_valid && out_ready && !no_idle) begin
      // after the word, ready goes low for a random stall unless stall_draw is zero
      stall_draw = $urandom_range(0, 12);
      out_ready  <= (stall_draw == 0);
      stall_left <= (stall_draw > 1) ? stall_draw - 1 : 0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One column word; valid stays high between back-to-back words.
  task automatic send_column(logic [COL_W-1:0] col);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_column <= col;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    columns_sent++;
  endtask

  // APB write: setup then access cycle, then back to idle.
  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipe before touching the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (heights_due != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_harmonics(logic [APB_DW-1:0] h [HARM_NUM]);
    wait_drained();
    for (int k = 0; k < HARM_NUM; k++) write_reg(APB_AW'(4 * k), h[k]);
    settings_used++;
  endtask

  // Mostly in-period columns, some past one period to exercise the wrap.
  function automatic logic [COL_W-1:0] pick_column();
    return ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(320, 511))
                                       : COL_W'($urandom_range(0, 319));
  endfunction

  initial begin
    logic [APB_DW-1:0] h [HARM_NUM];
    int n_items;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_column = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    columns_sent  = 0;
    settings_used = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all amplitudes zero after reset: invalid flag, height 0
    send_column(9'd0);
    send_column(9'd511);
    send_column(9'd160);

    // every harmonic at full amplitude, zero phase
    foreach (h[k]) h[k] = 32'hFFFF_0000;
    load_harmonics(h);
    // writes past the last harmonic must be dropped
    write_reg(APB_AW'(20), 32'hDEAD_BEEF);
    write_reg(APB_AW'(28), 32'hFFFF_FFFF);
    foreach (h[k]) send_column(COL_W'(k == 0 ? 0 : 64 * k));
    send_column(9'd319);
    send_column(9'd320);
    send_column(9'd511);
    send_column(9'd80);
    send_column(9'd240);

    // fundamental alone, smallest amplitude, largest phase
    foreach (h[k]) h[k] = '0;
    h[0] = 32'h0001_FFFF;
    load_harmonics(h);
    send_column(9'd0);
    send_column(9'd80);
    send_column(9'd160);
    send_column(9'd240);

    // fifth harmonic alone at full scale with half-turn phase
    foreach (h[k]) h[k] = '0;
    h[4] = 32'hFFFF_8000;
    load_harmonics(h);
    send_column(9'd0);
    send_column(9'd16);
    send_column(9'd511);

    // random settings, about 1300 columns in all
    for (int ph = 0; ph < 13; ph++) begin
      foreach (h[k]) begin
        case ($urandom_range(0, 3))
          0: h[k] = {16'h0000, 16'($urandom)};
          1: h[k] = {16'hFFFF, 16'($urandom)};
          default: h[k] = $urandom;
        endcase
      end
      if (ph == 6) foreach (h[k]) h[k][31:16] = '0;   // all silent again
      load_harmonics(h);
      no_idle = (ph % 4 == 3);
      n_items = 100;
      for (int i = 0; i < n_items; i++) begin
        if (ph == 2 && i == 10) hold_req <= 1'b1;
        send_column(pick_column());
      end
      no_idle = 1'b0;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (heights_due != 0);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d columns under %0d harmonic settings, checked %0d heights",
             columns_sent, settings_used, heights_seen);
    if (fail_count == 0 && heights_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
